// ===== design/tcphp_pkg.sv =====
// Package for the TCP header parser: request and result types, status codes,
// register indexes and the ones' complement add. No dependencies.
`default_nettype none

package tcphp_pkg;

  localparam int unsigned LengthBitsDefault = 16;
  localparam int unsigned CfgIndexBits = 8;

  localparam logic [CfgIndexBits-1:0] CFG_CHECKSUM_CHECK_EN = 8'd0;
  localparam logic [CfgIndexBits-1:0] CFG_PAYLOAD_REPORT_EN = 8'd1;

  localparam logic [5:0] HEADER_BYTES = 6'd20;
  localparam logic [3:0] MIN_HEADER_WORDS = 4'd5;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SHORT   = 2'd1,
    ST_OFFSET  = 2'd2,
    ST_OVERRUN = 2'd3
  } parse_status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } tcphp_in_t;

  typedef struct packed {
    logic [15:0]   source_port;
    logic [15:0]   destination_port;
    logic [31:0]   sequence_number;
    logic [31:0]   acknowledge_number;
    logic [3:0]    header_words;
    logic [7:0]    flag_bits;
    logic [15:0]   window_size;
    logic [15:0]   checksum_field;
    logic [15:0]   urgent_pointer;
    logic [15:0]   payload_length;
    parse_status_e parse_status;
    logic          checksum_bad;
  } tcphp_out_t;

  // Sixteen-bit ones' complement add with end-around carry.
  function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[15:0] + {15'd0, t[16]};
  endfunction

endpackage

`default_nettype wire

// ===== design/tcphp_in_reg.sv =====
// Input register of the TCP header parser; holds one byte request until the
// segment logic takes it. Depends on tcphp_pkg.
`default_nettype none

module tcphp_in_reg import tcphp_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire tcphp_in_t in_data_i,
  input  wire logic      advance_i,
  output logic           in_ready_o,
  output logic           valid_o,
  output tcphp_in_t      data_o
);

  logic      valid_q, valid_d;
  tcphp_in_t data_q;

  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ===== design/tcphp_core.sv =====
// Segment state of the TCP header parser: header capture, running checksum,
// byte count and the result of the final byte. Depends on tcphp_pkg.
`default_nettype none

module tcphp_core import tcphp_pkg::*; #(
  parameter int unsigned LengthBits = LengthBitsDefault
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      advance_i,
  input  wire tcphp_in_t data_i,
  input  wire logic      check_en_i,
  input  wire logic      report_en_i,
  output tcphp_out_t     result_o
);

  localparam logic [LengthBits-1:0] CountMax = '1;

  logic [LengthBits-1:0] cnt_q, cnt_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  pend_q, pend_d;
  logic [31:0] port_q, port_d;
  logic [31:0] seq_q, seq_d;
  logic [31:0] ack_q, ack_d;
  logic [3:0]  words_q, words_d;
  logic [7:0]  flags_q, flags_d;
  logic [15:0] win_q, win_d;
  logic [15:0] csum_q, csum_d;
  logic [15:0] urg_q, urg_d;

  logic [7:0]            b;
  logic                  sat;
  logic [15:0]           word;
  logic [15:0]           fin_sum;
  logic [LengthBits-1:0] hlen;
  logic [LengthBits-1:0] payload;
  parse_status_e         status;

  assign b = data_i.data_byte;

  always_comb begin
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    pend_d  = pend_q;
    port_d  = port_q;
    seq_d   = seq_q;
    ack_d   = ack_q;
    words_d = words_q;
    flags_d = flags_q;
    win_d   = win_q;
    csum_d  = csum_q;
    urg_d   = urg_q;
    sat     = (cnt_q == CountMax);
    word    = {pend_q, 8'h00};

    if (!sat) begin
      if (cnt_q < LengthBits'(4)) begin
        port_d = {port_q[23:0], b};
      end else if (cnt_q < LengthBits'(8)) begin
        seq_d = {seq_q[23:0], b};
      end else if (cnt_q < LengthBits'(12)) begin
        ack_d = {ack_q[23:0], b};
      end else if (cnt_q == LengthBits'(12)) begin
        words_d = b[7:4];
      end else if (cnt_q == LengthBits'(13)) begin
        flags_d = b;
      end else if (cnt_q < LengthBits'(16)) begin
        win_d = {win_q[7:0], b};
      end else if (cnt_q < LengthBits'(18)) begin
        csum_d = {csum_q[7:0], b};
      end else if (cnt_q < LengthBits'(20)) begin
        urg_d = {urg_q[7:0], b};
      end
      word  = cnt_q[0] ? {pend_q, b} : {b, 8'h00};
      cnt_d = cnt_q + LengthBits'(1);
      if (!cnt_q[0]) begin
        pend_d = b;
      end
    end

    fin_sum = fold_add(sum_q, word);
    if (!sat && cnt_q[0]) begin
      sum_d = fin_sum;
    end

    hlen    = LengthBits'({words_d, 2'b00});
    payload = cnt_d - hlen;
    if (cnt_d < LengthBits'(HEADER_BYTES)) begin
      status = ST_SHORT;
    end else if (words_d < MIN_HEADER_WORDS) begin
      status = ST_OFFSET;
    end else if (hlen > cnt_d) begin
      status = ST_OVERRUN;
    end else begin
      status = ST_OK;
    end

    result_o.source_port        = port_d[31:16];
    result_o.destination_port   = port_d[15:0];
    result_o.sequence_number    = seq_d;
    result_o.acknowledge_number = ack_d;
    result_o.header_words       = words_d;
    result_o.flag_bits          = flags_d;
    result_o.window_size        = win_d;
    result_o.checksum_field     = csum_d;
    result_o.urgent_pointer     = urg_d;
    result_o.parse_status       = status;
    result_o.payload_length     = (status == ST_OK && report_en_i && cnt_d > hlen) ?
                                  16'(payload) : 16'd0;
    result_o.checksum_bad       = status == ST_OK && check_en_i && csum_d != 16'd0 &&
                                  ~fin_sum != csum_d;

    if (data_i.last_byte) begin
      cnt_d   = '0;
      sum_d   = '0;
      pend_d  = '0;
      port_d  = '0;
      seq_d   = '0;
      ack_d   = '0;
      words_d = '0;
      flags_d = '0;
      win_d   = '0;
      csum_d  = '0;
      urg_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      sum_q   <= '0;
      pend_q  <= '0;
      port_q  <= '0;
      seq_q   <= '0;
      ack_q   <= '0;
      words_q <= '0;
      flags_q <= '0;
      win_q   <= '0;
      csum_q  <= '0;
      urg_q   <= '0;
    end else if (advance_i) begin
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      pend_q  <= pend_d;
      port_q  <= port_d;
      seq_q   <= seq_d;
      ack_q   <= ack_d;
      words_q <= words_d;
      flags_q <= flags_d;
      win_q   <= win_d;
      csum_q  <= csum_d;
      urg_q   <= urg_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/tcphp_out_reg.sv =====
// Result register of the TCP header parser; holds one result until the
// consumer takes it. Depends on tcphp_pkg.
`default_nettype none

module tcphp_out_reg import tcphp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       load_i,
  input  wire tcphp_out_t result_i,
  input  wire logic       out_ready_i,
  output logic            free_o,
  output logic            out_valid_o,
  output tcphp_out_t      out_data_o
);

  logic       valid_q, valid_d;
  tcphp_out_t data_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (free_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

// ===== design/tcp_header_parser_checksum.sv =====
// TCP header parser with running ones' complement checksum, top level.
// Depends on tcphp_pkg, tcphp_in_reg, tcphp_core and tcphp_out_reg.
// A final byte is held in the input register; its result is then held in the result register.
// Throughput: one byte per cycle, except that a final byte waits while the result register is full.
// Reset clears all segment state and sets both enables to one.
`default_nettype none

module tcp_header_parser_checksum import tcphp_pkg::*; #(
  parameter int unsigned LengthBits = LengthBitsDefault
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire tcphp_in_t               in_data_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output tcphp_out_t                   out_data_o,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [CfgIndexBits-1:0] cfg_index_i,
  input  wire logic                    cfg_data_i
);

  logic       check_en_q, check_en_d;
  logic       report_en_q, report_en_d;
  logic       req_valid;
  tcphp_in_t  req_data;
  logic       out_free;
  logic       advance;
  tcphp_out_t result;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    check_en_d  = check_en_q;
    report_en_d = report_en_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CHECKSUM_CHECK_EN: check_en_d  = cfg_data_i;
        CFG_PAYLOAD_REPORT_EN: report_en_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_en_q  <= 1'b1;
      report_en_q <= 1'b1;
    end else begin
      check_en_q  <= check_en_d;
      report_en_q <= report_en_d;
    end
  end

  assign advance = req_valid && (!req_data.last_byte || out_free);

  tcphp_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .advance_i  (advance),
    .in_ready_o (in_ready_o),
    .valid_o    (req_valid),
    .data_o     (req_data)
  );

  tcphp_core #(
    .LengthBits (LengthBits)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .data_i      (req_data),
    .check_en_i  (check_en_q),
    .report_en_i (report_en_q),
    .result_o    (result)
  );

  tcphp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && req_data.last_byte),
    .result_i    (result),
    .out_ready_i (out_ready_i),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // The input side only stalls while a finished result is waiting.
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  a_bad_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.parse_status != ST_OK |->
      out_data_o.payload_length == 16'd0 && !out_data_o.checksum_bad)
    else $error("payload or checksum flag set on a failed parse");

  a_ok_has_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.parse_status == ST_OK |->
      out_data_o.header_words >= MIN_HEADER_WORDS)
    else $error("ok status with short data offset");

  a_flag_needs_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.checksum_bad |-> out_data_o.checksum_field != 16'd0)
    else $error("checksum flagged against a zero field");

endmodule

`default_nettype wire
